FILE: rtl/assert_macros.svh
// Assertion macros for the RTL top level.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check an implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/aabb_pkg.sv
// Package for the bounding box block: widths, command codes, state enum, beat and
// control structs. Depends on nothing.
package aabb_pkg;
	localparam int COORD_WIDTH      = 16;
	localparam int MATRIX_FRAC_BITS = 12;
	localparam int FACTOR_WIDTH     = 16;

	typedef enum logic [2:0] {
		CMD_CLEAR     = 3'd0,
		CMD_ADD_VERT  = 3'd1,
		CMD_ADD_BOX   = 3'd2,
		CMD_LOAD_ROW  = 3'd3,
		CMD_TRANSFORM = 3'd4,
		CMD_TEST_PT   = 3'd5,
		CMD_TEST_BOX  = 3'd6,
		CMD_NONE      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_XINIT,
		ST_XSTEP,
		ST_XFLUSH,
		ST_XDONE,
		ST_OUT
	} state_t;

	// Input beat: one command with its operands.
	typedef struct packed {
		logic [2:0]                     command;
		logic signed [COORD_WIDTH-1:0]  px;
		logic signed [COORD_WIDTH-1:0]  py;
		logic signed [COORD_WIDTH-1:0]  pz;
		logic signed [COORD_WIDTH-1:0]  qx;
		logic signed [COORD_WIDTH-1:0]  qy;
		logic signed [COORD_WIDTH-1:0]  qz;
		logic [1:0]                     row;
		logic signed [FACTOR_WIDTH-1:0] m0;
		logic signed [FACTOR_WIDTH-1:0] m1;
		logic signed [FACTOR_WIDTH-1:0] m2;
		logic signed [COORD_WIDTH-1:0]  m3;
	} cmd_beat_t;

	// Result beat: test outcome, transformed box and center.
	typedef struct packed {
		logic                          hit;
		logic signed [COORD_WIDTH-1:0] tmin_x;
		logic signed [COORD_WIDTH-1:0] tmin_y;
		logic signed [COORD_WIDTH-1:0] tmin_z;
		logic signed [COORD_WIDTH-1:0] tmax_x;
		logic signed [COORD_WIDTH-1:0] tmax_y;
		logic signed [COORD_WIDTH-1:0] tmax_z;
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [COORD_WIDTH-1:0] center_z;
	} box_beat_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       latch;    // capture input beat
		logic       exec;     // run the latched command
		logic       xinit;    // reset running min/max
		logic       xstep;    // issue one corner/row product
		logic [2:0] corner;
		logic [1:0] rowsel;
		logic       xdone;    // commit transformed box
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic       present;
		logic [2:0] cmd;
	} sts_t;

	localparam int unsigned ROW_LAST    = 2;
	localparam int unsigned CORNER_LAST = 7;
endpackage

FILE: rtl/aabb_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface aabb_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/aabb_ctrl.sv
// Controller for the bounding box block: sequences commands and the transform walk.
// Depends on aabb_pkg.
module aabb_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  aabb_pkg::sts_t sts,
	output aabb_pkg::ctl_t ctl
);
	import aabb_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] corner_q;
	logic [1:0] row_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (sts.cmd == CMD_TRANSFORM && sts.present) state_d = ST_XINIT;
				else state_d = ST_OUT;
			end
			ST_XINIT: state_d = ST_XSTEP;
			ST_XSTEP: begin
				if (corner_q == 3'(CORNER_LAST) && row_q == 2'(ROW_LAST)) state_d = ST_XFLUSH;
			end
			// Let the last product leave the pipeline stage.
			ST_XFLUSH: state_d = ST_XDONE;
			ST_XDONE: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		out_valid  = (state_q == ST_OUT);
		ctl        = '0;
		ctl.latch  = (state_q == ST_IDLE) && in_valid;
		ctl.exec   = (state_q == ST_EXEC);
		ctl.xinit  = (state_q == ST_XINIT);
		ctl.xstep  = (state_q == ST_XSTEP);
		ctl.corner = corner_q;
		ctl.rowsel = row_q;
		ctl.xdone  = (state_q == ST_XDONE);
	end

	// Advance state and the corner/row walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= '0;
			row_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_XINIT) begin
				corner_q <= '0;
				row_q    <= '0;
			end else if (state_q == ST_XSTEP) begin
				if (row_q == 2'(ROW_LAST)) begin
					row_q    <= '0;
					corner_q <= corner_q + 3'd1;
				end else begin
					row_q <= row_q + 2'd1;
				end
			end
		end
	end
endmodule

FILE: rtl/aabb_dp.sv
// Datapath for the bounding box block: base box, matrix, transform MAC, tests.
// Depends on aabb_pkg.
module aabb_dp #(
	parameter int CW = 16,
	parameter int FB = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aabb_pkg::ctl_t     ctl,
	output aabb_pkg::sts_t     sts,
	input  logic [2:0]         command,
	input  logic signed [CW-1:0] px, py, pz, qx, qy, qz,
	input  logic [1:0]         row,
	input  logic signed [15:0] m0, m1, m2,
	input  logic signed [CW-1:0] m3,
	output logic               hit,
	output logic signed [CW-1:0] tmin [3],
	output logic signed [CW-1:0] tmax [3],
	output logic signed [CW-1:0] cen [3]
);
	import aabb_pkg::*;

	localparam int PW = CW + 16 + 1;        // one product
	localparam int AW = PW + 3 + FB;        // sum of four terms
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic [2:0]         cmd_q;
	logic signed [CW-1:0] p_q [3];
	logic signed [CW-1:0] q_q [3];
	logic [1:0]         row_q;
	logic signed [15:0] mf_q [3];
	logic signed [CW-1:0] mt_q;

	logic signed [CW-1:0] bmin_q [3];
	logic signed [CW-1:0] bmax_q [3];
	logic               present_q;
	logic signed [15:0] mat_q [3][3];
	logic signed [CW-1:0] trn_q [3];
	logic signed [CW-1:0] lo_q [3];
	logic signed [CW-1:0] hi_q [3];
	logic               hit_q;

	// Product stage registers.
	logic signed [PW-1:0] pr_s1 [3];
	logic signed [AW-1:0] tr_s1;
	logic [1:0]           r_s1;
	logic                 v_s1;

	assign sts.present = present_q;
	assign sts.cmd     = cmd_q;
	assign hit         = hit_q;

	// Capture the input beat.
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= command;
			p_q[0] <= px; p_q[1] <= py; p_q[2] <= pz;
			q_q[0] <= qx; q_q[1] <= qy; q_q[2] <= qz;
			row_q <= row;
			mf_q[0] <= m0; mf_q[1] <= m1; mf_q[2] <= m2;
			mt_q <= m3;
		end
	end

	// Execute the latched command on stored state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			hit_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				bmin_q[i] <= CMAX;
				bmax_q[i] <= CMIN;
				trn_q[i]  <= '0;
				for (int j = 0; j < 3; j++) mat_q[i][j] <= '0;
			end
		end else if (ctl.exec) begin
			hit_q <= 1'b0;
			unique case (cmd_q)
				CMD_CLEAR: begin
					present_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						bmin_q[i] <= CMAX;
						bmax_q[i] <= CMIN;
					end
				end
				CMD_ADD_VERT, CMD_ADD_BOX: begin
					present_q <= 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (p_q[i] < bmin_q[i]) bmin_q[i] <= p_q[i];
						if (cmd_q == CMD_ADD_VERT) begin
							if (p_q[i] > bmax_q[i]) bmax_q[i] <= p_q[i];
						end else if (q_q[i] > bmax_q[i]) begin
							bmax_q[i] <= q_q[i];
						end
					end
				end
				CMD_LOAD_ROW: begin
					if (row_q != 2'd3) begin
						for (int j = 0; j < 3; j++) mat_q[row_q][j] <= mf_q[j];
						trn_q[row_q] <= mt_q;
					end
				end
				CMD_TEST_PT: begin
					hit_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						if (p_q[i] < tmin[i] || p_q[i] > tmax[i]) hit_q <= 1'b0;
				end
				CMD_TEST_BOX: begin
					hit_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						if (tmin[i] > q_q[i] || tmax[i] < p_q[i]) hit_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Corner selection and three products per step.
	logic signed [CW-1:0] c [3];
	always_comb begin
		c[0] = (ctl.corner[1] ^ ctl.corner[0]) ? bmax_q[0] : bmin_q[0];
		c[1] = ctl.corner[1] ? bmax_q[1] : bmin_q[1];
		c[2] = ctl.corner[2] ? bmax_q[2] : bmin_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= ctl.xstep;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++)
			pr_s1[j] <= PW'(mat_q[ctl.rowsel][j]) * PW'(c[j]);
		tr_s1 <= AW'(trn_q[ctl.rowsel]) <<< FB;
		r_s1  <= ctl.rowsel;
	end

	// Sum, floor shift, saturate.
	logic signed [AW-1:0] acc, sh;
	logic signed [CW-1:0] v;
	always_comb begin
		acc = AW'(pr_s1[0]) + AW'(pr_s1[1]) + AW'(pr_s1[2]) + tr_s1;
		sh  = acc >>> FB;
		if (sh > AW'(CMAX)) v = CMAX;
		else if (sh < AW'(CMIN)) v = CMIN;
		else v = sh[CW-1:0];
	end

	// Track running min/max and commit the transformed box.
	logic signed [CW:0] hs [3];
	always_comb begin
		for (int i = 0; i < 3; i++) hs[i] = ((CW+1)'(lo_q[i]) + (CW+1)'(hi_q[i])) >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				tmin[i] <= '0; tmax[i] <= '0; cen[i] <= '0;
			end
		end else if (ctl.xdone) begin
			for (int i = 0; i < 3; i++) begin
				tmin[i] <= lo_q[i];
				tmax[i] <= hi_q[i];
				cen[i]  <= hs[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.xinit) begin
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= CMAX; hi_q[i] <= CMIN;
			end
		end else if (v_s1) begin
			if (v < lo_q[r_s1]) lo_q[r_s1] <= v;
			if (v > hi_q[r_s1]) hi_q[r_s1] <= v;
		end
	end
endmodule

FILE: rtl/aabb_accumulate_transform_test.sv
// Top level of the bounding box block: channels, controller and datapath.
// Depends on aabb_pkg, aabb_if, aabb_ctrl, aabb_dp and assert_macros.svh.
//
// Usage:
//  Input channel in carries one command beat: command, px..qz, row, m0..m3.
//  Output channel out carries one result beat per command: hit, the
//  transformed box and its center, all taken after the command ran.
//  One beat is worked at a time. Clear, add, load, test, the unused code and
//  a transform with no base box go from the accepting edge through the
//  decode state to the output state, which raises result valid.
//  Transform with a present base box goes from the accepting edge through
//  one decode, one init, 24 corner/row steps on the shared three-multiplier
//  unit, one pipeline flush and one commit before it raises result valid.
//  Input ready is high only while the block is idle; the next beat is
//  accepted the cycle after the result is taken.
//  When the receiver stalls the result holds stable on out until ready.
//  Reset (arst_n low) empties the base box, zeroes the matrix and the
//  transformed box, and leaves the block idle.
`include "assert_macros.svh"
module aabb_accumulate_transform_test (
	input logic clk,
	input logic arst_n,
	aabb_if.sink   in,
	aabb_if.source out
);
	import aabb_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic signed [COORD_WIDTH-1:0] tmin [3], tmax [3], cen [3];
	logic hit;

	aabb_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.sts, .ctl
	);

	aabb_dp #(.CW(COORD_WIDTH), .FB(MATRIX_FRAC_BITS)) u_dp (
		.clk, .arst_n, .ctl, .sts,
		.command(in.data.command),
		.px(in.data.px), .py(in.data.py), .pz(in.data.pz),
		.qx(in.data.qx), .qy(in.data.qy), .qz(in.data.qz),
		.row(in.data.row),
		.m0(in.data.m0), .m1(in.data.m1), .m2(in.data.m2), .m3(in.data.m3),
		.hit, .tmin, .tmax, .cen
	);

	// Drive the result payload.
	always_comb begin
		out.data.hit      = hit;
		out.data.tmin_x   = tmin[0];
		out.data.tmin_y   = tmin[1];
		out.data.tmin_z   = tmin[2];
		out.data.tmax_x   = tmax[0];
		out.data.tmax_y   = tmax[1];
		out.data.tmax_z   = tmax[2];
		out.data.center_x = cen[0];
		out.data.center_y = cen[1];
		out.data.center_z = cen[2];
	end

	`ASSERT_IMPL(a_excl, clk, arst_n, in.ready, !out.valid, "ready and valid together")
	`ASSERT_NEXT(a_acc, clk, arst_n, in.valid && in.ready, !in.ready, "second beat taken")
	`ASSERT_NEXT(a_hold, clk, arst_n, out.valid && !out.ready, out.valid && $stable(out.data.hit), "result dropped while stalled")
endmodule

FILE: tb/testbench.sv
// Self-checking bench for the bounding box block: drives command beats, predicts
// every result beat and compares the whole beat. Depends on aabb_pkg, aabb_if
// and the top level aabb_accumulate_transform_test.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import aabb_pkg::*;

	localparam longint CMAX = 32767;
	localparam longint CMIN = -32768;
	localparam int CYCLE_LIMIT = 400000;

	// Box predictor and store of expected result beats.
	class box_scoreboard;
		longint base_lo[3], base_hi[3], xf_lo[3], xf_hi[3], mid[3], mat[12];
		bit present;
		box_beat_t pending[$];
		int errors, n_cmds, n_hits, n_xforms, n_checked;

		function new();
			for (int i = 0; i < 12; i++) mat[i] = 0;
			for (int i = 0; i < 3; i++) begin
				xf_lo[i] = 0; xf_hi[i] = 0; mid[i] = 0;
			end
			empty_base();
		endfunction

		function void empty_base();
			for (int i = 0; i < 3; i++) begin
				base_lo[i] = CMAX; base_hi[i] = CMIN;
			end
			present = 0;
		endfunction

		function longint clamp(longint v);
			return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
		endfunction

		// Map the eight base corners through the matrix; keep per-axis extremes.
		function void transform_box();
			longint lo[3], hi[3], c[3], acc, v;
			if (!present) return;
			for (int r = 0; r < 3; r++) begin
				lo[r] = CMAX; hi[r] = CMIN;
			end
			for (int k = 0; k < 8; k++) begin
				c[0] = ((k + 1) & 2) ? base_hi[0] : base_lo[0];
				c[1] = (k & 2) ? base_hi[1] : base_lo[1];
				c[2] = (k & 4) ? base_hi[2] : base_lo[2];
				for (int r = 0; r < 3; r++) begin
					acc = mat[r*4]*c[0] + mat[r*4+1]*c[1] + mat[r*4+2]*c[2]
						+ mat[r*4+3]*4096;
					v = clamp(acc >>> 12);
					if (v < lo[r]) lo[r] = v;
					if (v > hi[r]) hi[r] = v;
				end
			end
			for (int r = 0; r < 3; r++) begin
				xf_lo[r] = lo[r]; xf_hi[r] = hi[r];
				mid[r] = (lo[r] + hi[r]) >>> 1;
			end
		endfunction

		// Apply one accepted command and queue its result.
		function void note(cmd_beat_t b);
			longint p[3], q[3], hv;
			box_beat_t e;
			bit h;
			p[0] = b.px; p[1] = b.py; p[2] = b.pz;
			q[0] = b.qx; q[1] = b.qy; q[2] = b.qz;
			h = 0;
			n_cmds++;
			case (b.command)
				CMD_CLEAR: empty_base();
				CMD_ADD_VERT, CMD_ADD_BOX: begin
					for (int i = 0; i < 3; i++) begin
						hv = (b.command == CMD_ADD_VERT) ? p[i] : q[i];
						if (p[i] < base_lo[i]) base_lo[i] = p[i];
						if (hv > base_hi[i]) base_hi[i] = hv;
					end
					present = 1;
				end
				CMD_LOAD_ROW: if (b.row <= ROW_LAST) begin
					mat[b.row*4] = b.m0; mat[b.row*4+1] = b.m1;
					mat[b.row*4+2] = b.m2; mat[b.row*4+3] = b.m3;
				end
				CMD_TRANSFORM: begin
					if (present) n_xforms++;
					transform_box();
				end
				CMD_TEST_PT: begin
					h = 1;
					for (int i = 0; i < 3; i++)
						if (p[i] < xf_lo[i] || p[i] > xf_hi[i]) h = 0;
				end
				CMD_TEST_BOX: begin
					h = 1;
					for (int i = 0; i < 3; i++)
						if (xf_lo[i] > q[i] || xf_hi[i] < p[i]) h = 0;
				end
				default: ;
			endcase
			n_hits += h;
			e.hit = h;
			e.tmin_x = 16'(xf_lo[0]); e.tmin_y = 16'(xf_lo[1]); e.tmin_z = 16'(xf_lo[2]);
			e.tmax_x = 16'(xf_hi[0]); e.tmax_y = 16'(xf_hi[1]); e.tmax_z = 16'(xf_hi[2]);
			e.center_x = 16'(mid[0]); e.center_y = 16'(mid[1]); e.center_z = 16'(mid[2]);
			pending.push_back(e);
		endfunction

		// Compare one result beat against the oldest expectation.
		function void check(box_beat_t a);
			box_beat_t e;
			n_checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", a);
				return;
			end
			e = pending.pop_front();
			if (a !== e) begin
				errors++;
				if (errors <= 10) begin
					$display("beat %0d: hit %b/%b min %0d %0d %0d / %0d %0d %0d",
						n_checked, e.hit, a.hit, e.tmin_x, e.tmin_y, e.tmin_z,
						a.tmin_x, a.tmin_y, a.tmin_z);
					$display("  max %0d %0d %0d / %0d %0d %0d ctr %0d %0d %0d / %0d %0d %0d",
						e.tmax_x, e.tmax_y, e.tmax_z, a.tmax_x, a.tmax_y, a.tmax_z,
						e.center_x, e.center_y, e.center_z,
						a.center_x, a.center_y, a.center_z);
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	aabb_if #(.payload_t(cmd_beat_t)) cmd_ch (clk);
	aabb_if #(.payload_t(box_beat_t)) res_ch (clk);
	box_scoreboard sb = new();
	int cycles;
	bit no_gaps;

	aabb_accumulate_transform_test uut (
		.clk(clk), .arst_n(arst_n), .in(cmd_ch.sink), .out(res_ch.source)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// Bound the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results pending", sb.pending.size());
			$display("aabb_accumulate_transform_test: mismatch");
			$finish;
		end
	end

	function int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 5);
	endfunction

	// Offer one command beat and hold it until accepted.
	task send(input cmd_beat_t b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= b;
		do @(negedge clk); while (!cmd_ch.ready);
		@(posedge clk);
		sb.note(b);
	endtask

	task drain();
		cmd_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function cmd_beat_t beat(logic [2:0] c, int x, int y, int z, int a, int b, int d);
		cmd_beat_t t;
		t = '0;
		t.command = c;
		t.px = 16'(x); t.py = 16'(y); t.pz = 16'(z);
		t.qx = 16'(a); t.qy = 16'(b); t.qz = 16'(d);
		return t;
	endfunction

	function cmd_beat_t row_beat(int r, int f0, int f1, int f2, int tr);
		cmd_beat_t t;
		t = beat(CMD_LOAD_ROW, 0, 0, 0, 0, 0, 0);
		t.row = 2'(r); t.m0 = 16'(f0); t.m1 = 16'(f1); t.m2 = 16'(f2); t.m3 = 16'(tr);
		return t;
	endfunction

	function logic signed [15:0] rand_coord();
		return ($urandom_range(0, 1) == 0) ? 16'($urandom)
			: 16'($signed($urandom_range(0, 4000)) - 2000);
	endfunction

	// Mostly well-formed traffic: build a box, load a matrix, transform, test.
	function cmd_beat_t rand_beat();
		cmd_beat_t t;
		int sel;
		t = '0;
		t.row = 2'($urandom);
		t.m0 = 16'($urandom); t.m1 = 16'($urandom);
		t.m2 = 16'($urandom); t.m3 = 16'($urandom);
		t.px = rand_coord(); t.py = rand_coord(); t.pz = rand_coord();
		t.qx = rand_coord(); t.qy = rand_coord(); t.qz = rand_coord();
		sel = $urandom_range(0, 99);
		if (sel < 4) t.command = CMD_CLEAR;
		else if (sel < 24) t.command = CMD_ADD_VERT;
		else if (sel < 34) t.command = CMD_ADD_BOX;
		else if (sel < 50) begin
			t.command = CMD_LOAD_ROW;
			t.row = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			if ($urandom_range(0, 1)) begin
				t.m0 = 16'($signed($urandom_range(0, 8192)) - 4096);
				t.m1 = 16'($signed($urandom_range(0, 8192)) - 4096);
				t.m2 = 16'($signed($urandom_range(0, 8192)) - 4096);
			end
		end
		else if (sel < 62) t.command = CMD_TRANSFORM;
		else if (sel < 78) t.command = CMD_TEST_PT;
		else if (sel < 96) t.command = CMD_TEST_BOX;
		else t.command = CMD_NONE;
		return t;
	endfunction

	// Take result beats with random stalls.
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(negedge clk); while (!res_ch.valid);
			sb.check(res_ch.data);
			@(posedge clk);
		end
	end

	initial begin
		cmd_beat_t t;
		no_gaps = 0;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tests on the zero box, empty transform, extremes, odd cases.
		send(beat(CMD_TEST_PT, 0, 0, 0, 0, 0, 0));
		send(beat(CMD_TEST_BOX, -1, -1, -1, 1, 1, 1));
		send(beat(CMD_TRANSFORM, 0, 0, 0, 0, 0, 0));
		send(row_beat(0, 4096, 0, 0, 0));
		send(row_beat(1, 0, 4096, 0, 16));
		send(row_beat(2, 0, 0, 4096, -16));
		send(row_beat(3, 32767, 32767, 32767, 32767));
		send(beat(CMD_ADD_VERT, 100, -200, 300, 0, 0, 0));
		send(beat(CMD_ADD_BOX, 50, 50, 50, -50, -50, -50));
		send(beat(CMD_TRANSFORM, 0, 0, 0, 0, 0, 0));
		send(beat(CMD_TEST_PT, 100, -184, 284, 0, 0, 0));
		send(beat(CMD_TEST_BOX, 101, 0, 0, 200, 0, 0));
		send(beat(CMD_NONE, -1, -1, -1, -1, -1, -1));
		send(beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		send(beat(CMD_TRANSFORM, 0, 0, 0, 0, 0, 0));
		send(beat(CMD_ADD_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
		send(row_beat(0, -32768, 32767, -32768, 32767));
		send(row_beat(1, 32767, 32767, 32767, -32768));
		send(row_beat(2, -32768, -32768, -32768, -32768));
		send(beat(CMD_TRANSFORM, 0, 0, 0, 0, 0, 0));
		send(beat(CMD_TEST_PT, 32767, -32768, 0, 0, 0, 0));
		send(beat(CMD_TEST_BOX, -32768, -32768, -32768, 32767, 32767, 32767));

		// Hold off until every result is back, then random traffic.
		drain();
		for (int n = 0; n < 900; n++) begin
			if (n % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
			if (n == 450) drain();
			send(rand_beat());
		end
		drain();

		$display("%0d commands, %0d box transforms, %0d hits, %0d results checked",
			sb.n_cmds, sb.n_xforms, sb.n_hits, sb.n_checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("aabb_accumulate_transform_test: match");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("aabb_accumulate_transform_test: mismatch");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_if.sv
rtl/aabb_ctrl.sv
rtl/aabb_dp.sv
rtl/aabb_accumulate_transform_test.sv
tb/testbench.sv
